// ----- rtl/core/bspu_pkg.sv -----
// Shared types, constants and helper functions for the bit stream pack/unpack core.
package bspu_pkg;

    localparam int STORE_BYTES = 1024;
    localparam int TOTAL_BITS  = STORE_BYTES * 8;
    localparam int HEAD_W      = $clog2(TOTAL_BITS + 1);
    localparam int OUT_HEAD_W  = 14;
    localparam int BANK_DEPTH  = (STORE_BYTES + 1) / 2;
    localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    typedef logic [HEAD_W-1:0]     t_head;
    typedef logic [HEAD_W:0]       t_head_sum;
    typedef logic [OUT_HEAD_W-1:0] t_head_out;
    typedef logic [BANK_AW-1:0]    t_bank_addr;

    localparam t_head_sum TOTAL_SUM = t_head_sum'(TOTAL_BITS);

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] write_data;
        logic [3:0] bit_count;
    } t_in;

    typedef struct packed {
        logic [7:0] read_value;
        t_head_out  head_after;
        logic       overflow;
    } t_out;

    // One item after head lookup and address generation.
    typedef struct packed {
        t_cmd       command;
        logic [7:0] data;
        logic [3:0] count;
        logic [2:0] off;
        logic       lo_odd;
        t_bank_addr even_addr;
        t_bank_addr odd_addr;
        logic       active;
        logic       overflow;
        t_head_out  head_after;
    } t_issue;

    // Write port traffic for both byte banks.
    typedef struct packed {
        logic       even_we;
        t_bank_addr even_addr;
        logic [7:0] even_data;
        logic       odd_we;
        t_bank_addr odd_addr;
        logic [7:0] odd_data;
    } t_bank_wr;

    function automatic logic [7:0] low_mask(input logic [3:0] n);
        logic [7:0] m;
        m = (n >= 4'd8) ? 8'hff : ~(8'hff << n[2:0]);
        return m;
    endfunction

endpackage

// ----- rtl/core/bspu_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bspu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bspu_issue.sv -----
// Head registers, overflow check and bank address generation.
module bspu_issue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  bspu_pkg::t_in   i_item,
    output bspu_pkg::t_issue o_issue
);

    bspu_pkg::t_head     r_write_head;
    bspu_pkg::t_head     r_read_head;
    bspu_pkg::t_head     head;
    bspu_pkg::t_head_sum sum;
    bspu_pkg::t_head     n_head;
    logic [3:0]          count;
    logic                ovf;
    logic                active;
    logic [bspu_pkg::HEAD_W-4:0] at;
    logic [bspu_pkg::HEAD_W-3:0] at_next;

    always_comb begin
        count   = i_item.bit_count[3] ? 4'd8 : i_item.bit_count;
        head    = (i_item.command == bspu_pkg::CMD_READ) ? r_read_head : r_write_head;
        sum     = {1'b0, head} + bspu_pkg::t_head_sum'(count);
        ovf     = (count != 4'd0) && (sum > bspu_pkg::TOTAL_SUM);
        active  = (count != 4'd0) && !ovf;
        n_head  = active ? sum[bspu_pkg::HEAD_W-1:0] : head;
        at      = head[bspu_pkg::HEAD_W-1:3];
        at_next = {1'b0, at} + {{(bspu_pkg::HEAD_W-3){1'b0}}, 1'b1};

        o_issue.command    = i_item.command;
        o_issue.data       = i_item.write_data & bspu_pkg::low_mask(count);
        o_issue.count      = count;
        o_issue.off        = head[2:0];
        o_issue.lo_odd     = at[0];
        // Even bank holds the even byte of the pair, odd bank the odd one.
        o_issue.even_addr  = at_next[bspu_pkg::BANK_AW:1];
        o_issue.odd_addr   = at[bspu_pkg::BANK_AW:1];
        o_issue.active     = active;
        o_issue.overflow   = ovf;
        o_issue.head_after = bspu_pkg::t_head_out'(n_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_head <= '0;
            r_read_head  <= '0;
        end else if (i_accept && active) begin
            if (i_item.command == bspu_pkg::CMD_READ) begin
                r_read_head <= n_head;
            end else begin
                r_write_head <= n_head;
            end
        end
    end

endmodule

// ----- rtl/core/bspu_rmw.sv -----
// Forwarding, field extraction and byte-pair merge for the second stage.
module bspu_rmw (
    input  bspu_pkg::t_issue   i_issue,
    input  logic [7:0]         i_even_rdata,
    input  logic [7:0]         i_odd_rdata,
    input  bspu_pkg::t_bank_wr i_last_wr,
    output logic [7:0]         o_read_value,
    output bspu_pkg::t_bank_wr o_wr
);

    logic [7:0]  even_byte;
    logic [7:0]  odd_byte;
    logic [7:0]  lo_byte;
    logic [7:0]  hi_byte;
    logic [15:0] pair;
    logic [15:0] ext;
    logic [7:0]  new_lo;
    logic [7:0]  new_hi;
    logic [4:0]  end_bit;
    logic        lo_we;
    logic        hi_we;

    always_comb begin
        // Take the previous write when it hit the same entry this cycle's read saw stale.
        even_byte = (i_last_wr.even_we && (i_last_wr.even_addr == i_issue.even_addr))
                    ? i_last_wr.even_data : i_even_rdata;
        odd_byte  = (i_last_wr.odd_we && (i_last_wr.odd_addr == i_issue.odd_addr))
                    ? i_last_wr.odd_data : i_odd_rdata;
        lo_byte   = i_issue.lo_odd ? odd_byte : even_byte;
        hi_byte   = i_issue.lo_odd ? even_byte : odd_byte;

        pair = {hi_byte, lo_byte} >> i_issue.off;
        o_read_value = (i_issue.active && (i_issue.command == bspu_pkg::CMD_READ))
                       ? (pair[7:0] & bspu_pkg::low_mask(i_issue.count)) : 8'h00;

        ext     = {8'h00, i_issue.data} << i_issue.off;
        new_lo  = (lo_byte & ~(8'hff << i_issue.off)) | ext[7:0];
        new_hi  = ext[15:8];
        end_bit = {2'b00, i_issue.off} + {1'b0, i_issue.count};
        lo_we   = i_issue.active && (i_issue.command == bspu_pkg::CMD_WRITE);
        hi_we   = lo_we && (end_bit > 5'd8);

        o_wr.even_we   = i_issue.lo_odd ? hi_we : lo_we;
        o_wr.even_addr = i_issue.even_addr;
        o_wr.even_data = i_issue.lo_odd ? new_hi : new_lo;
        o_wr.odd_we    = i_issue.lo_odd ? lo_we : hi_we;
        o_wr.odd_addr  = i_issue.odd_addr;
        o_wr.odd_data  = i_issue.lo_odd ? new_lo : new_hi;
    end

endmodule

// ----- rtl/core/bit_stream_pack_unpack_core.sv -----
// An accepted item is registered into the issue stage, then its result into the output register.
// The core takes one item per cycle unless the output stalls; the byte store is split into even
// and odd byte banks so a field spanning two bytes is read and written back in one pass.
// The last bank write is forwarded to the next item's read of the same entry.
// Reset clears both bit heads and the pipeline; store contents stay undefined.
module bit_stream_pack_unpack_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bspu_pkg::t_in i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bspu_pkg::t_out o_data
);

    bspu_pkg::t_issue   issue;
    bspu_pkg::t_issue   r_s1;
    logic               r_s1_valid;
    bspu_pkg::t_bank_wr wr;
    bspu_pkg::t_bank_wr r_last_wr;
    bspu_pkg::t_out     r_out;
    logic               r_out_valid;
    logic [7:0]         even_rdata;
    logic [7:0]         odd_rdata;
    logic [7:0]         read_value;
    logic               accept;
    logic               s1_advance;

    assign s1_advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready    = !r_s1_valid || s1_advance;
    assign accept     = i_valid && o_ready;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    bspu_issue u_issue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_data),
        .o_issue  (issue)
    );

    bspu_ram #(
        .WIDTH (8),
        .DEPTH (bspu_pkg::BANK_DEPTH)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (s1_advance && wr.even_we),
        .i_waddr (wr.even_addr),
        .i_wdata (wr.even_data),
        .i_re    (accept),
        .i_raddr (issue.even_addr),
        .o_rdata (even_rdata)
    );

    bspu_ram #(
        .WIDTH (8),
        .DEPTH (bspu_pkg::BANK_DEPTH)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (s1_advance && wr.odd_we),
        .i_waddr (wr.odd_addr),
        .i_wdata (wr.odd_data),
        .i_re    (accept),
        .i_raddr (issue.odd_addr),
        .o_rdata (odd_rdata)
    );

    bspu_rmw u_rmw (
        .i_issue      (r_s1),
        .i_even_rdata (even_rdata),
        .i_odd_rdata  (odd_rdata),
        .i_last_wr    (r_last_wr),
        .o_read_value (read_value),
        .o_wr         (wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_last_wr.even_we <= 1'b0;
            r_last_wr.odd_we  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
                // Hold the most recent bank write for forwarding.
                r_last_wr   <= wr;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= issue;
        end
        if (s1_advance) begin
            r_out.read_value <= read_value;
            r_out.head_after <= r_s1.head_after;
            r_out.overflow   <= r_s1.overflow;
        end
    end

endmodule

// ----- bench/bit_stream_pack_unpack_core_checker.sv -----
// Checker for the bit stream core: mirrors the byte store and heads, compares every result.
module bit_stream_pack_unpack_core_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  bspu_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  bspu_pkg::t_out i_out_data,
    output int             o_errors,
    output int             o_outstanding
);
    import bspu_pkg::*;

    logic [7:0]  shadow_bytes [STORE_BYTES];
    int unsigned wr_pos;
    int unsigned rd_pos;
    t_out        stream_reports [$];

    function automatic logic [7:0] field_mask(input int unsigned n);
        return (n >= 8) ? 8'hff : 8'((1 << n) - 1);
    endfunction

    // Apply one field to the shadow store and return the result it should produce.
    function automatic t_out access_stream(input t_in f);
        t_out        r;
        int unsigned n;
        int unsigned pos;
        int unsigned at;
        int unsigned off;
        int unsigned room;
        int unsigned v;
        int unsigned hi;
        n = (f.bit_count > 4'd8) ? 8 : f.bit_count;
        pos = (f.command == CMD_READ) ? rd_pos : wr_pos;
        r.read_value = 8'h00;
        r.overflow = 1'b0;
        if (n != 0) begin
            if (pos + n > TOTAL_BITS) begin
                r.overflow = 1'b1;
            end else begin
                at = pos >> 3;
                off = pos & 7;
                room = 8 - off;
                if (f.command == CMD_READ) begin
                    v = shadow_bytes[at];
                    v = v >> off;
                    if (n > room) begin
                        hi = shadow_bytes[at + 1];
                        v = v | (hi << room);
                    end
                    r.read_value = v[7:0] & field_mask(n);
                end else begin
                    // keep bits below the head, clear everything above the field
                    v = f.write_data & field_mask(n);
                    v = v << off;
                    shadow_bytes[at] = (shadow_bytes[at] & field_mask(off)) | v[7:0];
                    if (n > room)
                        shadow_bytes[at + 1] = v[15:8];
                end
                pos = pos + n;
            end
        end
        if (f.command == CMD_READ)
            rd_pos = pos;
        else
            wr_pos = pos;
        r.head_after = t_head_out'(pos);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            wr_pos = 0;
            rd_pos = 0;
            stream_reports.delete();
            foreach (shadow_bytes[k])
                shadow_bytes[k] = 8'h00;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (stream_reports.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result: read_value %0d head_after %0d overflow %0d",
                                 i_out_data.read_value, i_out_data.head_after,
                                 i_out_data.overflow);
                end else begin
                    want = stream_reports.pop_front();
                    if (i_out_data.read_value !== want.read_value ||
                        i_out_data.head_after !== want.head_after ||
                        i_out_data.overflow !== want.overflow) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"mismatch: read_value %0d/%0d head_after %0d/%0d",
                                      " overflow %0d/%0d (expected/actual)"},
                                     want.read_value, i_out_data.read_value,
                                     want.head_after, i_out_data.head_after,
                                     want.overflow, i_out_data.overflow);
                    end
                end
            end
            // append the prediction at the tail of the queue
            if (i_in_valid && i_in_ready)
                stream_reports.insert(stream_reports.size(), access_stream(i_in_data));
        end
        o_outstanding = stream_reports.size();
    end

endmodule

// ----- bench/bit_stream_pack_unpack_core_test.sv -----
// Top of the bit stream core bench: clock, reset, field stimulus, receiver and verdict.
module bit_stream_pack_unpack_core_test;
    import bspu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_data  = '0;
    logic i_ready = 1'b0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    int errors;
    int outstanding;
    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_arm = 1'b0;

    // Head positions as seen by the sender, used to keep reads on written bytes.
    int unsigned wr_bits = 0;
    int unsigned rd_bits = 0;
    int          wr_overflows = 0;
    int          rd_overflows = 0;

    bit_stream_pack_unpack_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    bit_stream_pack_unpack_core_checker stream_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_data     (i_data),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_data    (o_data),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_in make_field(input t_cmd c, input logic [7:0] d,
                                       input logic [3:0] n);
        t_in f;
        f.command = c;
        f.write_data = d;
        f.bit_count = n;
        return f;
    endfunction

    function automatic int unsigned clamp_count(input logic [3:0] n);
        return (n > 4'd8) ? 8 : n;
    endfunction

    // A read may touch only bytes already written, unless it overflows and touches nothing.
    function automatic bit read_allowed(input logic [3:0] n);
        int unsigned c;
        c = clamp_count(n);
        return (c == 0) || (rd_bits + c > TOTAL_BITS) ||
               (rd_bits + c <= 8 * ((wr_bits + 7) / 8));
    endfunction

    task automatic offer(input t_in f);
        int unsigned c;
        c = clamp_count(f.bit_count);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= f;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (c != 0) begin
            if (f.command == CMD_READ) begin
                if (rd_bits + c > TOTAL_BITS)
                    rd_overflows++;
                else
                    rd_bits += c;
            end else begin
                if (wr_bits + c > TOTAL_BITS)
                    wr_overflows++;
                else
                    wr_bits += c;
            end
        end
    endtask

    task automatic random_field(input int write_pct, input int high_pct);
        t_in f;
        f.write_data = 8'($urandom);
        if ($urandom_range(99) < high_pct)
            f.bit_count = 4'($urandom_range(15, 8));
        else
            f.bit_count = 4'($urandom_range(7, 0));
        f.command = ($urandom_range(99) < write_pct) ? CMD_WRITE : CMD_READ;
        if (f.command == CMD_READ && !read_allowed(f.bit_count))
            f.command = CMD_WRITE;
        offer(f);
    endtask

    // Drop valid and hold until every transfer has produced its result.
    task automatic settle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin : receiver
        int hold_left;
        bit hold_spent;
        hold_left = 0;
        hold_spent = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_arm && !hold_spent) begin
                hold_left = HOLD_CYCLES;
                hold_spent = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Writes: full byte, single bit, data wider than the count, zero count,
        // saturated counts, fields spanning two bytes.
        offer(make_field(CMD_WRITE, 8'hff, 4'd8));
        offer(make_field(CMD_WRITE, 8'h00, 4'd1));
        offer(make_field(CMD_WRITE, 8'hff, 4'd3));
        offer(make_field(CMD_WRITE, 8'h5a, 4'd0));
        offer(make_field(CMD_WRITE, 8'ha5, 4'd15));
        offer(make_field(CMD_WRITE, 8'h3c, 4'd9));
        offer(make_field(CMD_WRITE, 8'h80, 4'd7));
        // Reads over the same fields, then into the cleared bits above the write head.
        offer(make_field(CMD_READ, 8'h00, 4'd0));
        offer(make_field(CMD_READ, 8'h00, 4'd8));
        offer(make_field(CMD_READ, 8'h00, 4'd1));
        offer(make_field(CMD_READ, 8'h00, 4'd3));
        offer(make_field(CMD_READ, 8'h00, 4'd15));
        offer(make_field(CMD_READ, 8'h00, 4'd7));
        offer(make_field(CMD_READ, 8'h00, 4'd8));
        offer(make_field(CMD_READ, 8'h00, 4'd5));
        // Back-to-back write then read of the same bytes.
        offer(make_field(CMD_WRITE, 8'hff, 4'd8));
        offer(make_field(CMD_READ, 8'h00, 4'd3));
        offer(make_field(CMD_WRITE, 8'h7e, 4'd4));
        offer(make_field(CMD_READ, 8'h00, 4'd4));
        offer(make_field(CMD_READ, 8'hff, 4'd1));
        settle();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 150)
                    hold_arm = 1'b1;
                random_field(55, 70);
            end
            settle();
        end

        // Fill the store to its end, then run the read head past it.
        while (wr_overflows < 4)
            random_field(60, 90);
        while (rd_overflows < 4)
            random_field(0, 90);
        settle();

        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
